// File: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

// File: src/utc2ep_pkg.sv
// constants, types and the month table for the date to epoch converter
package utc2ep_pkg;

    // field widths
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IN_W    = 56;
    localparam int unsigned OUT_W   = 40;
    localparam int unsigned TSEC_W  = 20;
    localparam int unsigned DAYS_W  = 24;
    localparam int unsigned YE_W    = 15;

    // year offset so that the shifted year is always positive and a multiple of 400 away
    // ye = years_since_1900 + 1900 + 8000, month carry folded in with its bias of 11
    localparam logic [15:0] YE_BIAS   = 16'd9889;
    // month bias so that the month index is nonnegative (11 times 12)
    localparam logic [8:0]  MON_BIAS  = 9'd132;
    // reciprocals for the constant divisions
    localparam logic [16:0] RECIP_12  = 17'd171;      // floor(v/12) = (v*171) >> 11
    localparam logic [29:0] RECIP_100 = 30'd20972;    // floor(v/100) = (v*20972) >> 21
    // sum of all constant day offsets: year shift, epoch day count, day-1
    localparam logic [31:0] DAY_OFFSET = 32'd3641469;
    localparam logic signed [41:0] SECS_PER_DAY = 42'sd86400;

    // operands of the day count stage
    typedef struct packed {
        logic [YE_W-1:0]   ye;     // shifted year, year + 8000
        logic [7:0]        q100;   // floor((ye + 99) / 100)
        logic [3:0]        mon;    // month 0..11
        logic [BYTE_W-1:0] mday;   // day of month, signed
    } t_day_in;

    // days before the first of a month in a common year
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            default: d = 9'd334;
        endcase
        return d;
    endfunction

endpackage

// File: src/utc2ep_days.sv
// day count since 1970-01-01 from shifted year, century quotient, month and day
module utc2ep_days (
    input  utc2ep_pkg::t_day_in       i_op,
    output logic [utc2ep_pkg::DAYS_W-1:0] o_days
);
    import utc2ep_pkg::*;

    logic        div4;
    logic        div100;
    logic        leap;
    logic [15:0] cent_back;
    logic [31:0] pos;
    logic [31:0] total;

    // gregorian leap rule on the shifted year (shift keeps mod 4 and mod 400)
    assign cent_back = 16'(i_op.q100) * 16'd100;
    assign div4      = (i_op.ye[1:0] == 2'b00);
    assign div100    = (cent_back == 16'(i_op.ye));
    assign leap      = div4 && (!div100 || (i_op.q100[1:0] == 2'b00));

    // positive parts: 365 y + ceil(y/4) + ceil(y/400) + month start + leap day
    assign pos = 32'(i_op.ye) * 32'd365
               + 32'((i_op.ye + 15'd3) >> 2)
               + 32'((i_op.q100 + 8'd3) >> 2)
               + 32'(month_start(i_op.mon))
               + 32'(leap && (i_op.mon > 4'd1));

    // modular sum keeps the two's complement result
    assign total = pos - 32'(i_op.q100) + {{24{i_op.mday[7]}}, i_op.mday} - DAY_OFFSET;
    assign o_days = total[DAYS_W-1:0];

endmodule

// File: src/utc_date_to_epoch_seconds.sv
// top level: broken-down utc date and time to signed seconds since the epoch
// Takes one date per cycle on the slave stream and gives signed 40-bit seconds since
// 1970-01-01 00:00:00 utc on the master stream. The pipeline holds four items in
// flight (input register, month/time stage, century stage, day stage) plus the output
// register; each stage has its own valid bit and moves whenever the stage after it is
// empty or moving, so throughput is one transaction per cycle while the output is taken.
// Month carries into the year with floor semantics, day, hour, minute and second are
// added linearly without range checks, and every input pattern fits the result width.
module utc_date_to_epoch_seconds (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [13:0] years_since_1900, [21:14] month_index, [29:22] day_of_month,
    // [37:30] hour_value, [45:38] minute_value, [53:46] second_value, [55:54] zero
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [39:0] epoch_seconds
    output logic [39:0] m_axis_tdata
);
    import utc2ep_pkg::*;

    // stage valid bits and advance conditions
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !m_axis_tvalid || m_axis_tready;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign s_axis_tready = rdy1;

    // stage 1: input register
    logic [IN_W-1:0] r_in;

    // stage 1 logic: month normalization, shifted year, time of day seconds
    logic [BYTE_W-1:0] f_mon, f_hour, f_min, f_sec;
    logic [YEAR_W-1:0] f_year;
    logic [8:0]        mon_off;
    logic [16:0]       mprod;
    logic [4:0]        q12;
    logic [8:0]        mrem;
    logic [15:0]       ye16;
    logic signed [TSEC_W-1:0] tsec1;

    assign f_year = r_in[13:0];
    assign f_mon  = r_in[21:14];
    assign f_hour = r_in[37:30];
    assign f_min  = r_in[45:38];
    assign f_sec  = r_in[53:46];

    assign mon_off = {f_mon[7], f_mon} + MON_BIAS;
    assign mprod   = 17'(mon_off) * RECIP_12;
    assign q12     = mprod[15:11];
    assign mrem    = mon_off - 9'(q12) * 9'd12;
    assign ye16    = {{2{f_year[13]}}, f_year} + 16'(q12) + YE_BIAS;
    assign tsec1   = $signed({{12{f_hour[7]}}, f_hour}) * 20'sd3600
                   + $signed({{12{f_min[7]}}, f_min}) * 20'sd60
                   + $signed({{12{f_sec[7]}}, f_sec});

    // stage 2 registers
    logic [YE_W-1:0]          r_ye2;
    logic [3:0]               r_mon2;
    logic [BYTE_W-1:0]        r_mday2;
    logic signed [TSEC_W-1:0] r_tsec2;

    // stage 2 logic: century quotient by reciprocal
    logic [29:0] qprod;
    assign qprod = 30'(r_ye2 + 15'd99) * RECIP_100;

    // stage 3 registers
    t_day_in                  r_op3;
    logic signed [TSEC_W-1:0] r_tsec3;

    // stage 3 logic: day count
    logic [DAYS_W-1:0] days3;
    utc2ep_days u_days (
        .i_op   (r_op3),
        .o_days (days3)
    );

    // stage 4 registers
    logic [DAYS_W-1:0]        r_days4;
    logic signed [TSEC_W-1:0] r_tsec4;

    // stage 4 logic: days to seconds plus time of day
    logic signed [41:0] sprod;
    logic [OUT_W-1:0]   n_out;
    assign sprod = $signed({{18{r_days4[DAYS_W-1]}}, r_days4}) * SECS_PER_DAY;
    assign n_out = sprod[OUT_W-1:0] + {{(OUT_W-TSEC_W){r_tsec4[TSEC_W-1]}}, r_tsec4};

    // output register
    logic [OUT_W-1:0] r_out;
    logic             r_ov;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_ov <= r_v4;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (rdy1 && s_axis_tvalid) begin
            r_in <= s_axis_tdata;
        end
        if (rdy2 && r_v1) begin
            r_ye2   <= ye16[YE_W-1:0];
            r_mon2  <= mrem[3:0];
            r_mday2 <= r_in[29:22];
            r_tsec2 <= tsec1;
        end
        if (rdy3 && r_v2) begin
            r_op3.ye   <= r_ye2;
            r_op3.q100 <= qprod[28:21];
            r_op3.mon  <= r_mon2;
            r_op3.mday <= r_mday2;
            r_tsec3    <= r_tsec2;
        end
        if (rdy4 && r_v3) begin
            r_days4 <= days3;
            r_tsec4 <= r_tsec3;
        end
        if (rdy5 && r_v4) begin
            r_out <= n_out;
        end
    end

endmodule

// File: src/utc2ep_checker.sv
// port-level checker for the date to epoch converter, bound to the top level
`include "assert_macros.svh"

module utc2ep_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // stalled result stays offered
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid, "output transaction dropped while stalled")

    // stalled result keeps its value
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        $stable(m_axis_tdata), "output data changed while stalled")

    // input only backs up when the output side is stalled
    `ASSERT_IMPL(a_in_stall, i_clk, i_rst_n, !s_axis_tready,
        m_axis_tvalid && !m_axis_tready, "input stalled without output back pressure")

    // nothing offered straight out of reset
    `ASSERT_IMPL(a_reset_empty, i_clk, i_rst_n, $rose(i_rst_n),
        !m_axis_tvalid, "result offered right after reset")

endmodule

bind utc_date_to_epoch_seconds utc2ep_checker u_utc2ep_checker (.*);
